// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue; depends on nothing.
package spq_pkg;

  // Queue depth and the widths that follow from it
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ECNT_W   = 5;

  // Operation codes carried on the input word
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes carried on the result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Source of the pair shown on the result word
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_LOWEST,
    SEL_INPUT
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     ins_en;
    logic     load_out;
    out_sel_t out_sel;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dup;
    logic ins_at_end;
  } spq_sts_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to CAPACITY (data, priority) pairs, highest priority first.
// Input word: insert, remove-lowest or clear. Every accepted word gives one result word.
// The result is registered and appears in the cycle after the input word is accepted.
// Throughput: one word per cycle while the receiver is ready; all cells compare the
// incoming priority and shift at once, and the result register is refilled as it is drained.
// Insert of an already stored priority returns status duplicate, into a full queue status
// full; both leave the queue unchanged and show the lowest pair. Remove shows the pair
// taken out; insert and unused codes show the lowest pair; clear and an empty queue show
// status empty with zero data and priority.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// When the receiver stalls, the result word holds and in_tready falls, so at most one
// result is ever waiting. Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] item_data, [63:32] item_priority
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] out_data, [63:32] out_priority,
                                  // [68:64] entry_count, [69] is_empty, [71:70] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  spq_cmd_t                cmd;
  spq_sts_t                sts;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] res_data;
  logic signed [VAL_W-1:0] res_prio;
  logic [ECNT_W-1:0]       entry_count;
  logic                    is_empty;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .sts         (sts),
    .cmd         (cmd),
    .count       (count),
    .status      (out_tuser),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  spq_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_tdata[31:0]),
    .in_prio  (in_tdata[63:32]),
    .count    (count),
    .sts      (sts),
    .out_data (res_data),
    .out_prio (res_prio)
  );

  // Result word packing
  assign out_tdata = {2'b00, is_empty, entry_count, res_prio, res_data};

endmodule

// ===== rtl/spq_datapath.sv =====
// Sorted cell array of the priority queue, with parallel compare and the output pair register.
// Depends on spq_pkg.
module spq_datapath import spq_pkg::*; (
  input  logic                    clk,
  input  spq_cmd_t                cmd,
  input  logic signed [VAL_W-1:0] in_data,
  input  logic signed [VAL_W-1:0] in_prio,
  input  logic [CNT_W-1:0]        count,
  output spq_sts_t                sts,
  output logic signed [VAL_W-1:0] out_data,
  output logic signed [VAL_W-1:0] out_prio
);

  logic signed [VAL_W-1:0] prio_r [CAPACITY];
  logic signed [VAL_W-1:0] data_r [CAPACITY];
  logic signed [VAL_W-1:0] out_data_r;
  logic signed [VAL_W-1:0] out_prio_r;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] eq;
  logic [IDX_W-1:0]    low_idx;

  // Per-cell compare against the incoming priority; only occupied cells count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (CNT_W'(i) < count);
      gt[i]    = valid[i] & (prio_r[i] > in_prio);
      eq[i]    = valid[i] & (prio_r[i] == in_prio);
    end
  end

  // Occupied cells form a prefix, and so do the higher-priority ones
  assign sts.dup        = |eq;
  assign sts.ins_at_end = (gt == valid);

  // Lowest pair sits in the last occupied cell
  assign low_idx = IDX_W'(count - CNT_W'(1));

  // Insert: higher cells hold, the first lower cell takes the new pair, the rest shift down
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins_en && !gt[i]) begin
        if (i == 0) begin
          prio_r[i] <= in_prio;
          data_r[i] <= in_data;
        end else if (gt[(i > 0) ? i - 1 : 0]) begin
          prio_r[i] <= in_prio;
          data_r[i] <= in_data;
        end else begin
          prio_r[i] <= prio_r[(i > 0) ? i - 1 : 0];
          data_r[i] <= data_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Result pair register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.out_sel)
        SEL_LOWEST: begin
          out_data_r <= data_r[low_idx];
          out_prio_r <= prio_r[low_idx];
        end
        SEL_INPUT: begin
          out_data_r <= in_data;
          out_prio_r <= in_prio;
        end
        default: begin
          out_data_r <= '0;
          out_prio_r <= '0;
        end
      endcase
    end
  end

  assign out_data = out_data_r;
  assign out_prio = out_prio_r;

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller of the priority queue: operation decode, fill count, status and result handshake.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic              out_ready,
  output logic              out_valid,
  input  spq_sts_t          sts,
  output spq_cmd_t          cmd,
  output logic [CNT_W-1:0]  count,
  output logic [1:0]        status,
  output logic [ECNT_W-1:0] entry_count,
  output logic              is_empty
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  logic [1:0]         status_r;
  logic [1:0]         status_nxt;
  logic [ECNT_W-1:0]  ecnt_r;
  logic               empty_r;
  logic               accept;
  logic               full;
  logic               none;

  assign in_ready = (state_r == S_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == CNT_W'(CAPACITY));
  assign none     = (fill_r == '0);

  // Operation decode
  always_comb begin
    fill_nxt       = fill_r;
    status_nxt     = ST_OK;
    cmd.ins_en     = 1'b0;
    cmd.load_out   = accept;
    cmd.out_sel    = SEL_LOWEST;
    unique case (op)
      OP_INSERT: begin
        if (sts.dup) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins_en  = accept;
          fill_nxt    = fill_r + CNT_W'(1);
          cmd.out_sel = sts.ins_at_end ? SEL_INPUT : SEL_LOWEST;
        end
      end
      OP_REMOVE: begin
        if (none) begin
          status_nxt  = ST_EMPTY;
          cmd.out_sel = SEL_ZERO;
        end else begin
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        fill_nxt    = '0;
        status_nxt  = ST_EMPTY;
        cmd.out_sel = SEL_ZERO;
      end
      default: begin
        if (none) begin
          status_nxt  = ST_EMPTY;
          cmd.out_sel = SEL_ZERO;
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      status_r <= ST_OK;
      ecnt_r   <= '0;
      empty_r  <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_ready && !accept) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (accept) begin
        fill_r   <= fill_nxt;
        status_r <= status_nxt;
        ecnt_r   <= ECNT_W'(fill_nxt);
        empty_r  <= (fill_nxt == '0);
      end
    end
  end

  assign out_valid   = (state_r == S_HOLD);
  assign count       = fill_r;
  assign status      = status_r;
  assign entry_count = ecnt_r;
  assign is_empty    = empty_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_CLEAR) |=> (fill_r == '0 && status_r == ST_EMPTY))
    else $error("clear left entries");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !cmd.ins_en)
    else $error("insert into full queue");

endmodule
